// ===== rtl/core/swm_pkg.sv =====
`timescale 1ns / 1ps

package swm_pkg;

	// default sizing of the count tree and the sample ring
	localparam int VALUE_BITS_DEF = 16;
	localparam int MAX_WINDOW_DEF = 4096;

	// fixed field widths
	localparam int SAMPLE_W = 16;
	localparam int MEDIAN_W = 16;
	localparam int CFG_W    = 13;
	localparam int CFG_MAX  = (1 << CFG_W) - 1;

	// window length after reset
	localparam logic [CFG_W-1:0] WS_RESET = 13'd3;

	// command broadcast from the controller to every tree level
	typedef struct packed {
		logic clr;   // write zero at the sweep address
		logic upd;   // read-modify-write one count on this level
		logic dec;   // the update removes a sample rather than adding one
	} swm_cmd_t;

endpackage

// ===== rtl/core/swm_cell.sv =====
`timescale 1ns / 1ps

module swm_cell #(
	parameter int VB    = swm_pkg::VALUE_BITS_DEF,
	parameter int DEPTH = 1,
	parameter int CW    = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  swm_pkg::swm_cmd_t cmd,
	input  logic [VB-1:0]    clr_addr,
	input  logic [VB-1:0]    upd_value,
	input  logic             in_valid,
	input  logic [VB-1:0]    in_path,
	input  logic [CW-1:0]    in_rank,
	output logic             out_valid,
	output logic [VB-1:0]    out_path,
	output logic [CW-1:0]    out_rank
);

	localparam int N = 1 << DEPTH;

	// counts of all nodes on this level of the tree
	logic [CW-1:0]    mem [N];

	logic [DEPTH-1:0] rd_addr;
	logic [DEPTH-1:0] addr_q;
	logic [CW-1:0]    cnt_q;
	logic [VB-1:0]    path_q;
	logic [CW-1:0]    rank_q;
	logic             wr_pend_q;
	logic             dec_q;
	logic             walk_q;
	logic [CW-1:0]    wr_data;
	logic             take;

	// an update addresses the sample's ancestor, a walk the left child of its node
	assign rd_addr = cmd.upd ? upd_value[VB-1 -: DEPTH] : in_path[VB-1 -: DEPTH];

	// count memory: sweep clear, write-back of an update, registered read
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			mem[clr_addr[DEPTH-1:0]] <= '0;
		end else if (wr_pend_q) begin
			mem[addr_q] <= wr_data;
		end
		if (cmd.upd || in_valid) begin
			cnt_q <= mem[rd_addr];
		end
		addr_q <= rd_addr;
		path_q <= in_path;
		rank_q <= in_rank;
	end

	// control of the update write-back and the walk token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pend_q <= 1'b0;
			dec_q     <= 1'b0;
			walk_q    <= 1'b0;
		end else begin
			wr_pend_q <= cmd.upd && !cmd.clr;
			dec_q     <= cmd.dec;
			walk_q    <= in_valid;
		end
	end

	assign wr_data = dec_q ? (cnt_q - 1'b1) : (cnt_q + 1'b1);

	// step of the walk: go right when the left subtree holds fewer than rank samples
	assign take      = cnt_q < rank_q;
	assign out_valid = walk_q;
	assign out_path  = path_q | (VB'(take) << (VB - DEPTH));
	assign out_rank  = take ? (rank_q - cnt_q) : rank_q;

`ifndef SYNTHESIS
	a_upd_walk_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.upd && in_valid))
		else $error("update and walk meet on one tree level");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_pend_q && dec_q) |-> (cnt_q != '0))
		else $error("count removed below zero");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_pend_q && !dec_q) |-> (cnt_q != '1))
		else $error("count overflow on insert");
`endif

endmodule

// ===== rtl/core/sliding_window_median.sv =====
`timescale 1ns / 1ps

// Sliding-window lower median of a stream of unsigned 16-bit samples.
// Input beats arrive on s_axis (tdata = sample), results leave on m_axis
// (tdata = median). The window length is written on the cfg channel; each
// write flushes the window, and cfg_ready is always high.
// Every sample is counted in a tree of counts with one memory per level;
// the levels form a chain of cells that update in parallel and hand the
// median search token from level to level, one level per cycle.
// A sample that does not fill the window is inserted and the block returns to
// idle. A sample that fills it runs through insert, search start, one step
// per tree level, result load and removal of the oldest sample. No result
// is given until the window holds K samples.
// After reset, and after every cfg write, the tree is cleared by a sweep over
// all 2^VALUE_BITS addresses during which s_axis_tready stays low.
// A finished result waits in the output register; while the receiver stalls,
// the block holds its next result and stops taking samples until the
// register frees up.
module sliding_window_median #(
	parameter int VALUE_BITS = swm_pkg::VALUE_BITS_DEF,
	parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [swm_pkg::SAMPLE_W-1:0] s_axis_tdata,   // [15:0] sample
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [swm_pkg::MEDIAN_W-1:0] m_axis_tdata,   // [15:0] median
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [swm_pkg::CFG_W-1:0]    cfg_data        // [12:0] window_size
);

	localparam int VB   = VALUE_BITS;
	localparam int MW   = swm_pkg::MEDIAN_W;
	localparam int KMAX = (MAX_WINDOW < swm_pkg::CFG_MAX) ? MAX_WINDOW : swm_pkg::CFG_MAX;
	localparam int CW   = $clog2(KMAX + 1);
	localparam int RAW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INS,
		ST_START,
		ST_WALK,
		ST_EMIT,
		ST_REM
	} state_t;

	// window length as used: zero means one, long windows clamp to the ring size
	function automatic logic [CW-1:0] eff_k(input logic [swm_pkg::CFG_W-1:0] ws);
		logic [CW-1:0] k;
		if (ws == '0) begin
			k = CW'(1);
		end else if (int'(ws) > KMAX) begin
			k = CW'(KMAX);
		end else begin
			k = CW'(ws);
		end
		return k;
	endfunction

	state_t            state_q;
	logic [VB-1:0]     clr_q;
	logic [CW-1:0]     keff_q;
	logic [CW-1:0]     fill_q;
	logic [RAW-1:0]    wp_q;
	logic [RAW-1:0]    rp_q;
	logic [RAW-1:0]    wp_next;
	logic [RAW-1:0]    rp_next;
	logic [VB-1:0]     ring_mem [MAX_WINDOW];
	logic [VB-1:0]     ring_rd_q;
	logic [VB-1:0]     med_q;
	logic [CW:0]       k_inc;
	logic [CW-1:0]     half;
	logic              accept;
	logic              out_free;
	logic              emit_go;
	swm_pkg::swm_cmd_t cmd;
	logic [VB-1:0]     upd_value;

	logic              valid_c [VB+1];
	logic [VB-1:0]     path_c  [VB+1];
	logic [CW-1:0]     rank_c  [VB+1];

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign emit_go       = (state_q == ST_EMIT) && out_free && !(cfg_valid && cfg_ready);

	// ring pointers wrap at the ring depth
	assign wp_next = (wp_q == RAW'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;
	assign rp_next = (rp_q == RAW'(MAX_WINDOW - 1)) ? '0 : rp_q + 1'b1;

	// rank of the lower median
	assign k_inc = {1'b0, keff_q} + 1'b1;
	assign half  = k_inc[CW:1];

	// commands to all tree levels
	always_comb begin
		cmd.clr   = (state_q == ST_CLEAR);
		cmd.upd   = accept || ((state_q == ST_EMIT) && out_free);
		cmd.dec   = (state_q == ST_EMIT);
		upd_value = (state_q == ST_EMIT) ? ring_rd_q : s_axis_tdata[VB-1:0];
	end

	// search token enters at the root
	assign valid_c[0] = (state_q == ST_START);
	assign path_c[0]  = '0;
	assign rank_c[0]  = half;

	// one cell per tree level, level 1 next to the root, leaves last
	for (genvar i = 0; i < VB; i++) begin : g_lvl
		swm_cell #(
			.VB    (VB),
			.DEPTH (i + 1),
			.CW    (CW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.clr_addr  (clr_q),
			.upd_value (upd_value),
			.in_valid  (valid_c[i]),
			.in_path   (path_c[i]),
			.in_rank   (rank_c[i]),
			.out_valid (valid_c[i+1]),
			.out_path  (path_c[i+1]),
			.out_rank  (rank_c[i+1])
		);
	end

	// sample ring and result holding registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ring_mem[wp_q] <= s_axis_tdata[VB-1:0];
		end
		if (state_q == ST_START) begin
			ring_rd_q <= ring_mem[rp_q];
		end
		if (valid_c[VB]) begin
			med_q <= path_c[VB];
		end
	end

	// sequencer: clear sweep, insert, search, result, removal of the oldest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			keff_q        <= eff_k(swm_pkg::WS_RESET);
			fill_q        <= '0;
			wp_q          <= '0;
			rp_q          <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
		end else begin
			// output register: load a new median, or release the beat once taken
			if (emit_go) begin
				m_axis_tvalid <= 1'b1;
				m_axis_tdata  <= MW'(med_q);
			end else if (m_axis_tvalid && m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				keff_q  <= eff_k(cfg_data);
				fill_q  <= '0;
				wp_q    <= '0;
				rp_q    <= '0;
				clr_q   <= '0;
				state_q <= ST_CLEAR;
			end else begin
				case (state_q)
					ST_CLEAR: begin
						clr_q <= clr_q + 1'b1;
						if (clr_q == '1) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (s_axis_tvalid) begin
							wp_q    <= wp_next;
							fill_q  <= fill_q + 1'b1;
							state_q <= ST_INS;
						end
					end
					ST_INS: begin
						state_q <= (fill_q == keff_q) ? ST_START : ST_IDLE;
					end
					ST_START: begin
						state_q <= ST_WALK;
					end
					ST_WALK: begin
						if (valid_c[VB]) begin
							state_q <= ST_EMIT;
						end
					end
					ST_EMIT: begin
						if (out_free) begin
							rp_q    <= rp_next;
							fill_q  <= fill_q - 1'b1;
							state_q <= ST_REM;
						end
					end
					ST_REM: begin
						state_q <= ST_IDLE;
					end
					default: begin
						state_q <= ST_CLEAR;
					end
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	a_room_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (fill_q < keff_q))
		else $error("sample taken with a full window");
	a_rank_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_c[VB] |-> (rank_c[VB] != '0))
		else $error("search ran out of rank before the leaves");
`endif

endmodule
